[src/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet in reset
`define CHK_IMPLY(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// implication checked on the following clock
`define CHK_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

[src/sndr_pkg.sv]
// Package: types, constants and sigmoid table for the sigmoid neuron
`timescale 1ns / 1ps
`default_nettype none
package sndr_pkg;
   localparam int MAX_COORDS_DEF = 8;
   localparam logic [3:0] CNT_RESET = 4'd8;
   localparam logic [15:0] LR_RESET = 16'd4096;
   localparam logic [15:0] W_RESET = 16'd5793;
   localparam logic REG_COUNT = 1'b0;
   localparam logic REG_LRATE = 1'b1;

   typedef enum logic {
      OP_EVAL  = 1'b0,
      OP_TRAIN = 1'b1
   } op_type;

   // controller -> datapath commands
   typedef struct packed {
      logic clr_acc;
      logic mac;        // accumulate w*x for index
      logic eval_fin;   // compute sigmoid from acc
      logic grad;       // compute g
      logic delta;      // compute delta
      logic upd;        // u[i] = w + round(delta*x)
      logic sq;         // sumsq += u^2
      logic sqrt_start;
      logic div_start;  // start w[i] = u/len
      logic wr_w;       // write divider result
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic div_done;
   } sts_type;

   function automatic logic [12:0] sig_tab(input logic [5:0] k);
      logic [12:0] t;
      unique case (k)
         6'd0: t = 13'd2048;  6'd1: t = 13'd2303;  6'd2: t = 13'd2550;
         6'd3: t = 13'd2782;  6'd4: t = 13'd2994;  6'd5: t = 13'd3184;
         6'd6: t = 13'd3349;  6'd7: t = 13'd3490;  6'd8: t = 13'd3608;
         6'd9: t = 13'd3705;  6'd10: t = 13'd3785; 6'd11: t = 13'd3850;
         6'd12: t = 13'd3902; 6'd13: t = 13'd3943; 6'd14: t = 13'd3976;
         6'd15: t = 13'd4002; 6'd16: t = 13'd4022; 6'd17: t = 13'd4038;
         6'd18: t = 13'd4051; 6'd19: t = 13'd4061; 6'd20: t = 13'd4069;
         6'd21: t = 13'd4075; 6'd22: t = 13'd4079; 6'd23: t = 13'd4083;
         6'd24: t = 13'd4086; 6'd25: t = 13'd4088; 6'd26: t = 13'd4090;
         6'd27: t = 13'd4091; 6'd28: t = 13'd4092; 6'd29: t = 13'd4093;
         6'd30: t = 13'd4094; 6'd31: t = 13'd4094; 6'd32: t = 13'd4096;
         default: t = 13'd4096;
      endcase
      return t;
   endfunction
endpackage
`default_nettype wire

[src/sndr_if.sv]
// Interfaces: valid/ready channels for request, response and register write
`timescale 1ns / 1ps
`default_nettype none
interface sndr_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] coord_value;
   logic        is_last;
   logic [12:0] target;
   logic [12:0] actual;
   modport source (output valid, req_type, coord_value, is_last, target, actual,
                   input ready);
   modport sink (input valid, req_type, coord_value, is_last, target, actual,
                 output ready);
endinterface

interface sndr_rsp_if;
   logic        valid;
   logic        ready;
   logic        done_type;
   logic [12:0] neuron_out;
   modport source (output valid, done_type, neuron_out, input ready);
   modport sink (input valid, done_type, neuron_out, output ready);
endinterface

interface sndr_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/sndr_ram.sv]
// Generic RAM with one write port, one read port and registered read
`timescale 1ns / 1ps
`default_nettype none
module sndr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[src/sndr_datapath.sv]
// Datapath: weights, coordinate buffer, MAC, training update, sqrt and divider
`timescale 1ns / 1ps
`default_nettype none
module sndr_datapath #(
   parameter int MAX_COORDS = sndr_pkg::MAX_COORDS_DEF,
   localparam int IW = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sndr_pkg::cmd_type    cmd,
   output sndr_pkg::sts_type         sts,
   // coordinate buffer write
   input  wire logic                 x_we,
   input  wire logic [IW-1:0]        x_waddr,
   input  wire logic [15:0]          x_wdata,
   // element being processed, read address presented the cycle before use
   input  wire logic [IW-1:0]        rd_idx,
   input  wire logic                 x_zero,   // element beyond received count
   input  wire logic [15:0]          lrate,
   input  wire logic [12:0]          target_in,
   input  wire logic [12:0]          actual_in,
   input  wire logic                 tgt_ld,
   output logic [12:0]               sig_out
);
   // x_zero and rd_idx are registered and applied to the read data, which arrives in the following cycle
   logic [IW-1:0] idx_ff;
   logic          xz_ff;
   logic [15:0]   w_rd, x_rd;
   logic          w_we;
   logic [15:0]   w_wdata;
   logic [MAX_COORDS-1:0] wv_ff;   // weight written since reset
   logic [IW-1:0] wr_idx_ff;

   sndr_ram #(.WIDTH(16), .DEPTH(1 << IW)) u_wram (
      .clock(clock), .we(w_we), .waddr(wr_idx_ff), .wdata(w_wdata),
      .raddr(rd_idx), .rdata(w_rd));
   sndr_ram #(.WIDTH(16), .DEPTH(1 << IW)) u_xram (
      .clock(clock), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
      .raddr(rd_idx), .rdata(x_rd));

   always_ff @(posedge clock) begin
      idx_ff <= rd_idx;
      xz_ff  <= x_zero;
   end

   logic signed [15:0] w_s, x_s;
   assign w_s = wv_ff[idx_ff] ? $signed(w_rd) : $signed(sndr_pkg::W_RESET);
   assign x_s = xz_ff ? 16'sd0 : $signed(x_rd);

   // ---------- evaluate: MAC ----------
   // valid follows the RAM read stage, then the product stage
   logic signed [31:0] prod_ff;
   logic               mac_d_ff;
   logic               prod_v_ff;
   logic signed [34:0] acc_ff;
   always_ff @(posedge clock) begin
      prod_ff <= w_s * x_s;
      if (reset) mac_d_ff <= 1'b0;
      else mac_d_ff <= cmd.mac;
      if (reset) prod_v_ff <= 1'b0;
      else prod_v_ff <= mac_d_ff;
      if (cmd.clr_acc) acc_ff <= '0;
      else if (prod_v_ff) acc_ff <= acc_ff + 35'(prod_ff);
   end

   // sigmoid
   logic        neg;
   logic [34:0] mag;
   logic [20:0] u12;
   logic [5:0]  k;
   logic [9:0]  f;
   logic [12:0] t0, t1, y;
   logic [22:0] df;
   always_comb begin
      neg = acc_ff[34];
      mag = neg ? 35'(-acc_ff) : 35'(acc_ff);
      u12 = mag[34:14];
      k   = {1'b0, u12[14:10]};
      f   = u12[9:0];
      t0  = sndr_pkg::sig_tab(k);
      t1  = sndr_pkg::sig_tab(k + 6'd1);
      df  = 23'(t1 - t0) * 23'(f) + 23'd512;
      if (u12 >= 21'd32768) y = 13'd4096;
      else y = t0 + 13'(df[22:10]);
   end
   always_ff @(posedge clock) begin
      if (cmd.eval_fin) sig_out <= neg ? 13'd4096 - y : y;
   end

   // ---------- train ----------
   logic [12:0] tgt_ff, act_ff;
   logic signed [13:0] diff_ff;
   logic signed [25:0] g_ff;      // act*(4096-act) rounded, signed
   logic signed [45:0] gprod;
   logic signed [33:0] delta_ff;
   always_ff @(posedge clock) begin
      if (tgt_ld) begin
         tgt_ff <= target_in;
         act_ff <= actual_in;
      end
   end
   logic signed [14:0] one_m;
   logic signed [28:0] ag;
   logic [28:0]        ag_abs;
   always_comb begin
      one_m  = 15'sd4096 - $signed({2'b0, act_ff});
      ag     = $signed({1'b0, act_ff}) * one_m;
      ag_abs = ag[28] ? 29'(-ag) : ag;
   end
   // lr*(t-a) first (registered), then times g
   logic signed [30:0] lrd_ff;
   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         g_ff    <= ag[28] ? -$signed(26'((ag_abs + 29'd2048) >> 12))
                           : $signed(26'((ag_abs + 29'd2048) >> 12));
         diff_ff <= $signed({1'b0, tgt_ff}) - $signed({1'b0, act_ff});
      end
      lrd_ff <= $signed({1'b0, lrate}) * diff_ff;
   end
   logic [45:0] gp_abs;
   always_comb begin
      gprod  = 46'(lrd_ff) * 46'(g_ff);
      gp_abs = gprod[45] ? 46'(-gprod) : gprod;
   end
   always_ff @(posedge clock) begin
      if (cmd.delta)
         delta_ff <= gprod[45] ? -$signed(34'((gp_abs + 46'd2048) >> 12))
                               : $signed(34'((gp_abs + 46'd2048) >> 12));
   end

   // update element: registered product then rounding; the write enable
   // trails the command by the RAM read and product stages
   logic signed [49:0] dx_ff;
   logic signed [15:0] w_d_ff;
   logic               upd_a_ff;
   logic               upd_d_ff;
   logic [49:0]        dx_abs;
   logic signed [29:0] dxr;
   always_ff @(posedge clock) begin
      dx_ff  <= delta_ff * x_s;
      w_d_ff <= w_s;
      if (reset) upd_a_ff <= 1'b0;
      else upd_a_ff <= cmd.upd;
      if (reset) upd_d_ff <= 1'b0;
      else upd_d_ff <= upd_a_ff;
   end
   always_comb begin
      dx_abs = dx_ff[49] ? 50'(-dx_ff) : dx_ff;
      dxr    = dx_ff[49] ? -$signed(30'((dx_abs + 50'd2097152) >> 22))
                         : $signed(30'((dx_abs + 50'd2097152) >> 22));
   end
   logic signed [29:0] u_ff [MAX_COORDS];
   logic [IW-1:0]      uidx_ff;
   always_ff @(posedge clock) begin
      uidx_ff <= idx_ff;
      if (upd_d_ff) u_ff[uidx_ff] <= 30'(w_d_ff) + dxr;
   end

   // sum of squares, element by element
   logic [IW-1:0] sq_idx;
   logic [29:0]   u_abs;
   logic [59:0]   sq_ff;
   logic          sq_v_ff;
   logic [62:0]   sumsq_ff;
   assign sq_idx = rd_idx;
   assign u_abs  = u_ff[sq_idx][29] ? 30'(-u_ff[sq_idx]) : 30'(u_ff[sq_idx]);
   always_ff @(posedge clock) begin
      sq_ff <= 60'(u_abs) * 60'(u_abs);
      if (reset) sq_v_ff <= 1'b0;
      else sq_v_ff <= cmd.sq;
      if (cmd.clr_acc) sumsq_ff <= '0;
      else if (sq_v_ff) sumsq_ff <= sumsq_ff + 63'(sq_ff);
   end

   // ---------- integer square root, one result bit per cycle ----------
   logic [71:0] rem_ff;
   logic [35:0] root_ff;
   logic [71:0] sv_ff;
   logic [5:0]  sq_cnt_ff;
   logic        sq_busy_ff;
   logic [73:0] trial;
   logic [73:0] rem_sh;
   always_comb begin
      rem_sh = {rem_ff, sv_ff[71:70]};
      trial  = rem_sh - {root_ff, 2'b01};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sq_busy_ff <= 1'b1;
         sq_cnt_ff  <= 6'd35;
         rem_ff     <= '0;
         root_ff    <= '0;
         sv_ff      <= {1'b0, sumsq_ff, 8'd0};
      end else if (sq_busy_ff) begin
         sv_ff <= {sv_ff[69:0], 2'b00};
         if (!trial[73]) begin
            rem_ff  <= trial[71:0];
            root_ff <= {root_ff[34:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[71:0];
            root_ff <= {root_ff[34:0], 1'b0};
         end
         if (sq_cnt_ff == 6'd0) sq_busy_ff <= 1'b0;
         else sq_cnt_ff <= sq_cnt_ff - 6'd1;
      end
   end
   assign sts.sqrt_done = !sq_busy_ff && !cmd.sqrt_start;

   // ---------- restoring divider: |u|*2^18 / len, rounded ----------
   logic [47:0] dnum_ff;
   logic [48:0] drem_ff;
   logic [47:0] dq_ff;
   logic [5:0]  dcnt_ff;
   logic        dbusy_ff, dneg_ff, dz_ff;
   logic [48:0] dshift, dsub;
   logic [29:0] ud_abs;
   logic signed [29:0] ud;
   assign ud     = u_ff[rd_idx];
   assign ud_abs = ud[29] ? 30'(-ud) : 30'(ud);
   always_comb begin
      dshift = {drem_ff[47:0], dnum_ff[47]};
      dsub   = dshift - {13'd0, root_ff};
   end
   logic [IW-1:0] didx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
         dcnt_ff  <= 6'd47;
         // numerator |u|*2^18 + len/2 gives the rounded quotient
         dnum_ff  <= {ud_abs, 18'd0} + {13'd0, root_ff[35:1]};
         drem_ff  <= '0;
         dneg_ff  <= ud[29];
         dz_ff    <= (root_ff == 36'd0);
         didx_ff  <= rd_idx;
         dq_ff    <= {{18{ud[29]}}, ud};
      end else if (dbusy_ff) begin
         if (dz_ff) begin
            dbusy_ff <= 1'b0;
         end else begin
            dnum_ff <= {dnum_ff[46:0], 1'b0};
            if (!dsub[48]) begin
               drem_ff <= dsub;
               dq_ff   <= {dq_ff[46:0], 1'b1};
            end else begin
               drem_ff <= dshift;
               dq_ff   <= {dq_ff[46:0], 1'b0};
            end
            if (dcnt_ff == 6'd0) dbusy_ff <= 1'b0;
            else dcnt_ff <= dcnt_ff - 6'd1;
         end
      end
   end
   assign sts.div_done = !dbusy_ff && !cmd.div_start;

   // signed, saturated result
   logic signed [48:0] wq;
   always_comb begin
      if (dz_ff) wq = 49'(signed'(dq_ff));
      else wq = dneg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
      if (wq > 49'sd32767) w_wdata = 16'h7FFF;
      else if (wq < -49'sd32768) w_wdata = 16'h8000;
      else w_wdata = wq[15:0];
   end
   assign w_we = cmd.wr_w;
   always_ff @(posedge clock) begin
      wr_idx_ff <= didx_ff;
      if (reset) wv_ff <= '0;
      else if (cmd.wr_w) wv_ff[didx_ff] <= 1'b1;
   end
endmodule
`default_nettype wire

[src/sndr_ctrl.sv]
// Controller: coordinate indexing and sequencing of evaluate and train passes
`timescale 1ns / 1ps
`default_nettype none
module sndr_ctrl #(
   parameter int MAX_COORDS = sndr_pkg::MAX_COORDS_DEF,
   localparam int IW = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1,
   localparam int CW = $clog2(MAX_COORDS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic              in_type,
   input  wire logic              in_last,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic                   out_type,
   input  wire logic [3:0]        count_cfg,
   output sndr_pkg::cmd_type      cmd,
   input  wire sndr_pkg::sts_type sts,
   output logic                   x_we,
   output logic [IW-1:0]          x_waddr,
   output logic [IW-1:0]          rd_idx,
   output logic                   x_zero,
   output logic                   tgt_ld,
   output logic                   clr_out
);
   typedef enum logic [3:0] {
      S_IN, S_MAC, S_MACW, S_SIG, S_GRAD, S_LRD, S_DELTA, S_UPD, S_UPDW,
      S_SQ, S_SQW, S_SQRT, S_DIV, S_DIVW, S_OUT
   } state_type;

   state_type   state_ff;
   logic [CW-1:0] cidx_ff, m_ff, i_ff, n;
   logic [2:0]  w_ff;
   logic        type_ff;

   always_comb begin
      if (count_cfg == 4'd0) n = CW'(1);
      else if (32'(count_cfg) > MAX_COORDS) n = CW'(MAX_COORDS);
      else n = CW'(count_cfg);
   end

   logic acc_in;
   assign in_ready = (state_ff == S_IN) && !out_valid;
   assign acc_in   = in_valid && in_ready;
   assign x_we     = acc_in && (cidx_ff < n);
   assign x_waddr  = cidx_ff[IW-1:0];
   assign rd_idx   = i_ff[IW-1:0];
   assign x_zero   = i_ff >= m_ff;
   assign tgt_ld   = acc_in && in_last;
   assign out_type = type_ff;

   always_comb begin
      cmd = '0;
      cmd.clr_acc    = acc_in && in_last;
      cmd.mac        = (state_ff == S_MAC);
      cmd.eval_fin   = (state_ff == S_SIG);
      cmd.grad       = (state_ff == S_GRAD);
      cmd.delta      = (state_ff == S_DELTA);
      cmd.upd        = (state_ff == S_UPD);
      cmd.sq         = (state_ff == S_SQ);
      cmd.sqrt_start = (state_ff == S_SQW) && (w_ff == 3'd0);
      cmd.div_start  = (state_ff == S_DIV);
      cmd.wr_w       = (state_ff == S_DIVW) && sts.div_done;
   end
   assign clr_out = (state_ff == S_GRAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IN;
         cidx_ff   <= '0;
         out_valid <= 1'b0;
         i_ff      <= '0;
         w_ff      <= '0;
      end else begin
         if (out_valid && out_ready) out_valid <= 1'b0;
         unique case (state_ff)
            S_IN: if (acc_in) begin
               if (cidx_ff < n) cidx_ff <= cidx_ff + CW'(1);
               if (in_last) begin
                  m_ff    <= (cidx_ff < n) ? cidx_ff + CW'(1) : cidx_ff;
                  cidx_ff <= '0;
                  type_ff <= in_type;
                  i_ff    <= '0;
                  state_ff <= (in_type == sndr_pkg::OP_TRAIN) ? S_GRAD : S_MAC;
               end
            end
            S_MAC: begin
               if (i_ff == n - CW'(1)) begin
                  state_ff <= S_MACW;
                  w_ff <= '0;
               end else i_ff <= i_ff + CW'(1);
            end
            S_MACW: begin
               w_ff <= w_ff + 3'd1;
               if (w_ff == 3'd3) state_ff <= S_SIG;
            end
            S_SIG: state_ff <= S_OUT;
            S_GRAD: state_ff <= S_LRD;
            S_LRD: state_ff <= S_DELTA;
            S_DELTA: state_ff <= S_UPD;
            S_UPD: begin
               if (i_ff == n - CW'(1)) begin
                  state_ff <= S_UPDW;
                  w_ff <= '0;
               end else i_ff <= i_ff + CW'(1);
            end
            S_UPDW: begin
               w_ff <= w_ff + 3'd1;
               if (w_ff == 3'd3) begin
                  state_ff <= S_SQ;
                  i_ff <= '0;
               end
            end
            S_SQ: begin
               if (i_ff == n - CW'(1)) begin
                  state_ff <= S_SQW;
                  w_ff <= 3'd4;
               end else i_ff <= i_ff + CW'(1);
            end
            S_SQW: begin
               w_ff <= w_ff - 3'd1;
               if (w_ff == 3'd0) state_ff <= S_SQRT;
            end
            S_SQRT: if (sts.sqrt_done) begin
               state_ff <= S_DIV;
               i_ff <= '0;
            end
            S_DIV: state_ff <= S_DIVW;
            S_DIVW: if (sts.div_done) begin
               if (i_ff == n - CW'(1)) state_ff <= S_OUT;
               else begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_DIV;
               end
            end
            S_OUT: if (!out_valid) begin
               out_valid <= 1'b1;
               state_ff  <= S_IN;
            end
            default: state_ff <= S_IN;
         endcase
      end
   end
endmodule
`default_nettype wire

[src/sigmoid_neuron_delta_rule.sv]
// Top level: single sigmoid neuron with delta-rule training
// Training runs the bit-serial root (36-step root) and, per weight, the bit-serial
//   divider (48-step divide).
// Throughput: one coordinate per cycle while buffering and no result is waiting; one vector at a time.
// Reset: synchronous, active high; weights read as round(2^14/sqrt(8)) until
//   first trained, coord_count 8, learning_rate 4096.
`timescale 1ns / 1ps
`default_nettype none
module sigmoid_neuron_delta_rule #(
   parameter int MAX_COORDS = sndr_pkg::MAX_COORDS_DEF,
   localparam int IW = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1
) (
   input wire logic clock,
   input wire logic reset,
   sndr_req_if.sink   req,
   sndr_rsp_if.source rsp,
   sndr_csr_if.sink   csr
);
   logic [3:0]  count_ff;
   logic [15:0] lrate_ff;

   // register writes always take a transfer
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= sndr_pkg::CNT_RESET;
         lrate_ff <= sndr_pkg::LR_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            sndr_pkg::REG_COUNT: count_ff <= csr.data[3:0];
            sndr_pkg::REG_LRATE: lrate_ff <= csr.data;
            default: ;
         endcase
      end
   end

   sndr_pkg::cmd_type cmd;
   sndr_pkg::sts_type sts;
   logic          x_we, x_zero, tgt_ld, clr_out, out_type;
   logic [IW-1:0] x_waddr, rd_idx;
   logic [12:0]   sig;

   sndr_ctrl #(.MAX_COORDS(MAX_COORDS)) u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_type(req.req_type), .in_last(req.is_last),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_type(out_type),
      .count_cfg(count_ff), .cmd(cmd), .sts(sts),
      .x_we(x_we), .x_waddr(x_waddr), .rd_idx(rd_idx), .x_zero(x_zero),
      .tgt_ld(tgt_ld), .clr_out(clr_out));

   sndr_datapath #(.MAX_COORDS(MAX_COORDS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .x_we(x_we), .x_waddr(x_waddr), .x_wdata(req.coord_value),
      .rd_idx(rd_idx), .x_zero(x_zero), .lrate(lrate_ff),
      .target_in(req.target), .actual_in(req.actual), .tgt_ld(tgt_ld),
      .sig_out(sig));

   // a train transfer reports zero
   logic zero_ff;
   always_ff @(posedge clock) begin
      if (reset) zero_ff <= 1'b0;
      else if (clr_out) zero_ff <= 1'b1;
      else if (cmd.eval_fin) zero_ff <= 1'b0;
   end
   assign rsp.done_type  = out_type;
   assign rsp.neuron_out = zero_ff ? 13'd0 : sig;
endmodule
`default_nettype wire

[src/sndr_checker.sv]
// Checker on the top-level ports, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sndr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_done_type,
   input wire logic [12:0] rsp_neuron_out
);
   `CHK_IMPLY(a_out_range, clock, reset, rsp_valid, rsp_neuron_out <= 13'd4096, "out range")
   `CHK_IMPLY(a_train_zero, clock, reset, rsp_valid && rsp_done_type, rsp_neuron_out == 13'd0, "train nonzero")
   `CHK_IMPLY(a_no_overlap, clock, reset, rsp_valid, !req_ready, "input taken while result waits")
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_neuron_out), "result dropped")
endmodule

bind sigmoid_neuron_delta_rule sndr_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_done_type(rsp.done_type),
   .rsp_neuron_out(rsp.neuron_out));
`default_nettype wire

[verif/tb_sigmoid_neuron_delta_rule.sv]
// Testbench for the sigmoid neuron: random vectors, scoreboard against a local neuron model
`timescale 1ns / 1ps
`default_nettype none
module tb_sigmoid_neuron_delta_rule;

   // coordinate transfer as queued for the driver
   typedef struct {
      sndr_pkg::op_type kind;
      logic [15:0] coord;
      logic        last;
      logic [12:0] tgt;
      logic [12:0] act;
      bit          drain;   // hold this transfer until all outputs are back
   } coord_item;

   typedef struct {
      sndr_pkg::op_type kind;
      logic [12:0] out;
   } neuron_result;

   // sigmoid samples at k/4, Q1.12
   localparam int SIG_PTS [33] = '{
      2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490,
      3608, 3705, 3785, 3850, 3902, 3943, 3976, 4002,
      4022, 4038, 4051, 4061, 4069, 4075, 4079, 4083,
      4086, 4088, 4090, 4091, 4092, 4093, 4094, 4094,
      4096};

   logic clock = 1'b0;
   logic reset = 1'b1;

   sndr_req_if req_if ();
   sndr_rsp_if rsp_if ();
   sndr_csr_if csr_if ();

   sigmoid_neuron_delta_rule u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Neuron model state: weights Q1.14, coordinate buffer, registers
   // ---------------------------------------------------------------
   longint             wts [8];
   logic signed [15:0] cbuf [8];
   int                 cidx;
   logic [3:0]         cnt_reg;
   logic [15:0]        lr_reg;

   coord_item    item_q [$];
   neuron_result out_q [$];

   int  errors;
   int  n_items, n_eval, n_train;
   int  gap_mode;          // 0: no idling on either side, 1: random gaps
   bit  long_hold_req;     // asks the monitor for one long receive stall

   function automatic longint rnd_shift(longint v, int s);
      longint h;
      h = longint'(1) << (s - 1);
      if (v >= 0) return (v + h) >>> s;
      return -((-v + h) >>> s);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [12:0] sigmoid_of(longint net);
      bit     neg;
      longint u, k, f, y;
      neg = net < 0;
      u = (neg ? -net : net) >>> 14;
      if (u >= (longint'(8) << 12)) begin
         y = 4096;
      end else begin
         k = u >>> 10;
         f = u & 1023;
         y = SIG_PTS[k] + (((SIG_PTS[k + 1] - SIG_PTS[k]) * f + 512) >>> 10);
      end
      return neg ? 13'(4096 - y) : 13'(y);
   endfunction

   // model one accepted coordinate; queues an expected output on the last one
   task automatic neuron_accept(coord_item it);
      int                n, m, i;
      longint            xs [8];
      longint            u [8];
      longint            net, g, delta, q, a;
      longint unsigned   sumsq, len;
      neuron_result      r;
      n = (cnt_reg == 0) ? 1 : (cnt_reg > 8) ? 8 : int'(cnt_reg);
      if (cidx < n) begin
         cbuf[cidx] = it.coord;
         cidx++;
      end
      if (!it.last) return;
      m = cidx;
      cidx = 0;
      for (i = 0; i < 8; i++) xs[i] = (i < m && i < n) ? longint'(cbuf[i]) : 0;
      r.kind = it.kind;
      r.out = '0;
      if (it.kind == sndr_pkg::OP_EVAL) begin
         net = 0;
         for (i = 0; i < n; i++) net += wts[i] * xs[i];
         r.out = sigmoid_of(net);
         n_eval++;
      end else begin
         g = rnd_shift(longint'(it.act) * (4096 - longint'(it.act)), 12);
         delta = rnd_shift(longint'(lr_reg) * (longint'(it.tgt) - longint'(it.act)) * g, 12);
         sumsq = 0;
         for (i = 0; i < n; i++) begin
            u[i] = wts[i] + rnd_shift(delta * xs[i], 22);
            a = u[i] < 0 ? -u[i] : u[i];
            sumsq += longint'(a) * longint'(a);
         end
         len = int_sqrt(sumsq << 8);
         for (i = 0; i < n; i++) begin
            q = u[i];
            if (len != 0) begin
               // divide rounding half away from zero
               a = u[i] < 0 ? -u[i] : u[i];
               q = ((a << 18) + longint'(len) / 2) / longint'(len);
               if (u[i] < 0) q = -q;
            end
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            wts[i] = q;
         end
         n_train++;
      end
      out_q.push_back(r);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gap_mode == 0 || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------
   // Driver: feeds coordinate transfers from item_q
   // ---------------------------------------------------------------
   int drv_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         drv_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            neuron_accept(item_q.pop_front());
            n_items++;
         end
         if (req_if.valid && !req_if.ready) begin
            // hold the offered transfer
         end else if (drv_gap > 0) begin
            drv_gap--;
            req_if.valid <= 1'b0;
         end else if (item_q.size() == 0 || (item_q[0].drain && out_q.size() != 0)) begin
            req_if.valid <= 1'b0;
         end else begin
            // head stays in the queue until its transfer completes
            req_if.valid       <= 1'b1;
            req_if.req_type    <= item_q[0].kind;
            req_if.coord_value <= item_q[0].coord;
            req_if.is_last     <= item_q[0].last;
            req_if.target      <= item_q[0].tgt;
            req_if.actual      <= item_q[0].act;
            drv_gap = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random backpressure, compares outputs in order
   // ---------------------------------------------------------------
   int hold_cnt;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (out_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected output: type %0d value %0d",
                                          rsp_if.done_type, rsp_if.neuron_out);
            end else begin
               neuron_result e;
               e = out_q.pop_front();
               if (rsp_if.done_type !== e.kind || rsp_if.neuron_out !== e.out) begin
                  errors++;
                  if (errors <= 10)
                     $display("output mismatch: exp type %0d value %0d, got type %0d value %0d",
                              e.kind, e.out, rsp_if.done_type, rsp_if.neuron_out);
               end
            end
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cnt = 400;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_if.ready <= 1'b0;
         end else if (gap_mode == 0 || $urandom_range(0, 99) < 70) begin
            rsp_if.ready <= 1'b1;
         end else begin
            hold_cnt = pick_gap();
            rsp_if.ready <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic add_item(sndr_pkg::op_type k, logic [15:0] c, logic l, logic [12:0] t,
                           logic [12:0] a, bit d = 1'b0);
      coord_item it;
      it.kind = k;
      it.coord = c;
      it.last = l;
      it.tgt = t;
      it.act = a;
      it.drain = d;
      item_q.push_back(it);
   endtask

   function automatic logic [12:0] rand_q12();
      if ($urandom_range(0, 7) == 0) return 13'($urandom_range(0, 8191));
      return 13'($urandom_range(0, 4096));
   endfunction

   // one vector of len coordinates with random content
   task automatic add_vec(int len, bit drain_first = 1'b0);
      sndr_pkg::op_type k;
      int     i;
      k = $urandom_range(0, 1) ? sndr_pkg::OP_TRAIN : sndr_pkg::OP_EVAL;
      for (i = 0; i < len; i++)
         add_item(k, 16'($urandom), i == len - 1, rand_q12(), rand_q12(),
                  drain_first && i == 0);
   endtask

   // wait for drained queues, then let the block settle
   task automatic wait_idle();
      forever begin
         @(posedge clock);
         if (item_q.size() == 0 && !req_if.valid && out_q.size() == 0) break;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [15:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      forever begin
         @(posedge clock);
         if (csr_if.ready) break;
      end
      if (idx == sndr_pkg::REG_COUNT) cnt_reg = val[3:0];
      else lr_reg = val;
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      int n, p, v, i;
      logic [3:0]  cnt_set [8];
      logic [15:0] lr_set [8];
      req_if.valid = 1'b0;
      req_if.req_type = sndr_pkg::OP_EVAL;
      req_if.coord_value = '0;
      req_if.is_last = 1'b0;
      req_if.target = '0;
      req_if.actual = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = sndr_pkg::REG_COUNT;
      csr_if.data = '0;
      errors = 0;
      n_items = 0;
      n_eval = 0;
      n_train = 0;
      gap_mode = 1;
      long_hold_req = 1'b0;
      cidx = 0;
      cnt_reg = sndr_pkg::CNT_RESET;
      lr_reg = sndr_pkg::LR_RESET;
      for (i = 0; i < 8; i++) begin
         wts[i] = longint'(sndr_pkg::W_RESET);
         cbuf[i] = '0;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: zero vector, coordinate extremes, short and long vectors, training with extreme target and actual
      for (i = 0; i < 8; i++) add_item(sndr_pkg::OP_EVAL, 16'h0000, i == 7, '0, '0);
      for (i = 0; i < 8; i++) add_item(sndr_pkg::OP_EVAL, 16'h7fff, i == 7, '0, '0);
      for (i = 0; i < 8; i++) add_item(sndr_pkg::OP_EVAL, 16'h8000, i == 7, '0, '0);
      add_item(sndr_pkg::OP_EVAL, 16'h1000, 1'b1, '0, '0);                 // short vector
      add_item(sndr_pkg::OP_TRAIN, 16'h8000, 1'b1, 13'd4096, 13'd0);
      add_item(sndr_pkg::OP_TRAIN, 16'h7fff, 1'b1, 13'd0, 13'd4096);
      add_item(sndr_pkg::OP_TRAIN, 16'h0800, 1'b1, 13'd8191, 13'd8191);    // out-of-range fields
      for (i = 0; i < 11; i++)
         add_item(sndr_pkg::OP_EVAL, 16'hf000, i == 10, '0, '0);           // long
      wait_idle();

      // directed: single weight driven to zero length, then recovered
      csr_write(sndr_pkg::REG_COUNT, 16'd1);
      add_item(sndr_pkg::OP_TRAIN, 16'h1000, 1'b1, 13'd2048, 13'd2048);
      add_item(sndr_pkg::OP_TRAIN, 16'h8000, 1'b1, 13'd4096, 13'd2048);
      add_item(sndr_pkg::OP_EVAL, 16'h7fff, 1'b1, '0, '0);
      add_item(sndr_pkg::OP_TRAIN, 16'h4000, 1'b1, 13'd4096, 13'd2048);
      add_item(sndr_pkg::OP_EVAL, 16'h7fff, 1'b1, '0, '0);
      wait_idle();

      // random phases over register settings, extremes included
      cnt_set = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd5, 4'd8, 4'd2};
      lr_set  = '{16'd65535, 16'd0, 16'd4096, 16'd200, 16'd65535, 16'd1, 16'd0, 16'd9000};
      for (p = 0; p < 8; p++) begin
         csr_write(sndr_pkg::REG_COUNT, 16'(cnt_set[p]));
         csr_write(sndr_pkg::REG_LRATE, (p == 7) ? 16'($urandom) : lr_set[p]);
         gap_mode = (p == 1) ? 0 : 1;
         n = (cnt_reg == 0) ? 1 : (cnt_reg > 8) ? 8 : int'(cnt_reg);
         if (p == 2) long_hold_req = 1'b1;   // receiver stalls while items keep coming
         v = 0;
         while (v < 150) begin
            if ($urandom_range(0, 9) < 8) begin
               add_vec(n, p == 4 && v > 60 && v < 70);
               v += n;
            end else begin
               i = $urandom_range(1, 12);
               add_vec(i);
               v += i;
            end
         end
         wait_idle();
      end

      wait_idle();
      $display("ran %0d coordinate transfers: %0d evaluations, %0d training steps",
               n_items, n_eval, n_train);
      $display("register settings covered count 0..15 and learning rate 0..65535");
      if (errors == 0) begin
         $display("tb_sigmoid_neuron_delta_rule OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("tb_sigmoid_neuron_delta_rule NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("timeout");
      $display("tb_sigmoid_neuron_delta_rule NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+src
src/sndr_pkg.sv
src/sndr_if.sv
src/sndr_ram.sv
src/sndr_datapath.sv
src/sndr_ctrl.sv
src/sigmoid_neuron_delta_rule.sv
src/sndr_checker.sv
verif/tb_sigmoid_neuron_delta_rule.sv
